/* rtl/spca_pkg.sv */
`timescale 1ns / 1ps

package spca_pkg;

    // input beat fields
    localparam int COST_IN_W = 8;
    localparam int DISP_W    = 6;
    localparam int COL_W     = 10;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_DISP_W = 7;
    localparam int PEN_W      = 12;

    localparam logic [NUM_DISP_W-1:0] NUM_DISP_RESET  = 7'd64;
    localparam logic [PEN_W-1:0]      SMALL_PEN_RESET = 12'd8;
    localparam logic [PEN_W-1:0]      LARGE_PEN_RESET = 12'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DISP  = 2'd0,
        CFG_SMALL_PEN = 2'd1,
        CFG_LARGE_PEN = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic first_col;
        logic first_row;
        logic in_range;
        logic done;
        logic use_up;
        logic use_dn;
        logic hb;
        logic vb;
    } t_item_flags;

    // floor(d / 3) for d below 64 by reciprocal multiply
    function automatic logic [4:0] div3(input logic [DISP_W-1:0] d);
        logic [11:0] p;
        p = {6'd0, d} * 12'd43;
        return p[11:7];
    endfunction

    // bank that holds the next disparity up
    function automatic logic [1:0] next_bank(input logic [1:0] r);
        logic [1:0] n;
        case (r)
            2'd0:    n = 2'd1;
            2'd1:    n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/sgm_path_cost_aggregation.sv */
`timescale 1ns / 1ps

// Horizontal and vertical path cost aggregation for semi-global matching.
// Input stream (s_axis_*): one beat per disparity of a pixel, disparities
// of a pixel from 0 upward, pixels in scan order; tuser flags the first
// pixel of a row and the first row. Output stream (m_axis_*): one beat per
// input beat with both path costs and their sum; tlast marks the last
// disparity of a pixel.
// Configuration writes (i_cfg_*) are always ready; the user must see that
// they are made only while the block is idle; the block does not enforce it.
// A beat is registered in stage 0, then stage 1, then the output register.
// Throughput: one beat per cycle while the receiver does not stall.
// Previous costs are spread over three banks by disparity modulo three,
// so the d-1, d, d+1 neighbors come from one read port per bank; one bank
// is written per beat; a write bypasses to a same-entry read in that cycle.
// The pipeline holds three beats; when the receiver stalls the stages fill
// up and s_axis_tready drops only once all are occupied.
// Reset clears the pipeline, sets the run minima to all ones and loads
// the default disparity count and penalties; cost stores are not cleared
// and hold data only once written, so no clearing pass follows reset.
module sgm_path_cost_aggregation #(
    parameter int MAX_DISP  = 64,
    parameter int MAX_WIDTH = 1024,
    parameter int COST_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // tdata: match_cost[7:0], disparity[13:8], column[23:14]
    input  logic [23:0]                           s_axis_tdata,
    // tuser: row_start[0], image_start_row[1]
    input  logic [1:0]                            s_axis_tuser,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: horizontal_cost, vertical_cost, summed_cost, zero fill
    output logic [((3*COST_BITS+8)/8)*8-1:0]      m_axis_tdata,
    // tlast: pixel_done
    output logic                                  m_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [spca_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [spca_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CB       = COST_BITS;
    localparam int OUT_W    = ((3*COST_BITS+8)/8)*8;
    localparam int DISP_LIM = (MAX_DISP < 64) ? MAX_DISP : 64;
    localparam int QD       = (DISP_LIM + 2) / 3;
    localparam int QW       = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HAW      = 1 + QW;
    localparam int VAW      = 1 + CW + QW;
    localparam int CAW      = 1 + CW;
    localparam int AW       = ((COST_BITS > spca_pkg::PEN_W) ? COST_BITS : spca_pkg::PEN_W) + 2;
    localparam int RSH      = 20;
    localparam int NDW      = spca_pkg::NUM_DISP_W;
    localparam int DW       = spca_pkg::DISP_W;
    localparam int KW       = spca_pkg::COL_W;

    localparam logic [RSH-1:0] COL_RECIP = RSH'((1 << RSH) / MAX_WIDTH);
    localparam logic [12:0]    WIDTH_C   = 13'(MAX_WIDTH);
    localparam logic [CB-1:0]  COST_MAX  = '1;

    function automatic logic [CB-1:0] f_path(
        input logic [spca_pkg::COST_IN_W-1:0] cost,
        input logic [CB-1:0]                  p_mid,
        input logic [CB-1:0]                  p_dn,
        input logic [CB-1:0]                  p_up,
        input logic                           use_dn,
        input logic                           use_up,
        input logic [CB-1:0]                  pmin,
        input logic [spca_pkg::PEN_W-1:0]     p1,
        input logic [spca_pkg::PEN_W-1:0]     p2
    );
        logic [AW-1:0] best;
        logic [AW-1:0] tot;
        best = AW'(pmin) + AW'(p2);
        if (AW'(p_mid) < best) best = AW'(p_mid);
        if (use_dn && (AW'(p_dn) + AW'(p1) < best)) best = AW'(p_dn) + AW'(p1);
        if (use_up && (AW'(p_up) + AW'(p1) < best)) best = AW'(p_up) + AW'(p1);
        tot = AW'(cost) + best;
        if (tot < AW'(pmin)) return '0;
        tot = tot - AW'(pmin);
        if (tot > AW'(COST_MAX)) return COST_MAX;
        return tot[CB-1:0];
    endfunction

    // configuration
    logic [NDW-1:0]             r_nd;
    logic [spca_pkg::PEN_W-1:0] r_p1;
    logic [spca_pkg::PEN_W-1:0] r_p2;

    // control state
    logic r_s0_v, r_s1_v, r_out_valid;
    logic r_bank, r_row;
    logic [CB-1:0] r_hprev, r_hrun, r_vrun;

    // stage 0 payload
    logic [spca_pkg::COST_IN_W-1:0] r_s0_cost;
    logic [DW-1:0]                  r_s0_d;
    logic [KW-1:0]                  r_s0_col;
    logic [KW-1:0]                  r_s0_colq;
    spca_pkg::t_item_flags          r_s0_flags;

    // stage 1 payload
    logic [spca_pkg::COST_IN_W-1:0] r_s1_cost;
    logic [DW-1:0]                  r_s1_d;
    logic [1:0]                     r_s1_r;
    logic [QW-1:0]                  r_s1_q;
    logic [CW-1:0]                  r_s1_colw;
    spca_pkg::t_item_flags          r_s1_flags;
    logic [CB-1:0]                  r_hq [3];
    logic [CB-1:0]                  r_vq [3];
    logic [CB-1:0]                  r_cmin;

    // output register
    logic [CB-1:0] r_out_h, r_out_vc;
    logic [CB:0]   r_out_sum;
    logic          r_out_last;

    // handshake
    logic w_en0, w_en1, w_en2, w_accept, w_rd_en, w_s1_go, w_we;

    assign w_en2    = !r_out_valid || m_axis_tready;
    assign w_en1    = !r_s1_v || w_en2;
    assign w_en0    = !r_s0_v || w_en1;
    assign w_accept = s_axis_tvalid && w_en0;
    assign w_rd_en  = r_s0_v && w_en1;
    assign w_s1_go  = r_s1_v && w_en2;
    assign w_we     = w_s1_go && r_s1_flags.in_range;

    assign s_axis_tready = w_en0;
    assign o_cfg_ready   = 1'b1;

    // input decode
    logic [spca_pkg::COST_IN_W-1:0] w_in_cost;
    logic [DW-1:0]                  w_in_d;
    logic [KW-1:0]                  w_in_col;
    logic [NDW-1:0]                 w_nd;
    logic [KW+RSH-1:0]              w_colprod;
    spca_pkg::t_item_flags          w_in_flags;

    assign w_in_cost = s_axis_tdata[7:0];
    assign w_in_d    = s_axis_tdata[13:8];
    assign w_in_col  = s_axis_tdata[23:14];
    assign w_colprod = (KW+RSH)'(w_in_col) * (KW+RSH)'(COL_RECIP);

    always_comb begin
        logic toggle_row;
        if (r_nd == '0) begin
            w_nd = NDW'(1);
        end else if ({2'b00, r_nd} > 9'(MAX_DISP)) begin
            w_nd = NDW'(MAX_DISP);
        end else begin
            w_nd = r_nd;
        end
        toggle_row           = s_axis_tuser[0] && (w_in_d == '0);
        w_in_flags.first_col = s_axis_tuser[0];
        w_in_flags.first_row = s_axis_tuser[1];
        w_in_flags.in_range  = NDW'(w_in_d) < w_nd;
        w_in_flags.done      = (NDW'(w_in_d) + NDW'(1)) == w_nd;
        w_in_flags.use_up    = (NDW'(w_in_d) + NDW'(1)) < w_nd;
        w_in_flags.use_dn    = w_in_d != '0;
        w_in_flags.hb        = r_bank;
        w_in_flags.vb        = r_row ^ toggle_row;
    end

    // stage 0: column wrap and bank addresses
    logic [22:0]   w_colmul, w_colrem, w_colfix;
    logic [CW-1:0] w_colw;
    logic [4:0]    w_qd, w_qup, w_qdn;
    logic [1:0]    w_r;
    logic [DW-1:0] w_three_q;
    logic [QW-1:0] w_rq [3];
    logic [HAW-1:0] w_h_raddr [3];
    logic [VAW-1:0] w_v_raddr [3];
    logic [CAW-1:0] w_c_raddr;

    assign w_colmul  = 23'(r_s0_colq) * 23'(WIDTH_C);
    assign w_colrem  = 23'(r_s0_col) - w_colmul;
    assign w_colfix  = (w_colrem >= 23'(MAX_WIDTH)) ? w_colrem - 23'(MAX_WIDTH) : w_colrem;
    assign w_colw    = w_colfix[CW-1:0];
    assign w_qd      = spca_pkg::div3(r_s0_d);
    assign w_three_q = DW'({w_qd, 1'b0}) + DW'(w_qd);
    assign w_r       = 2'(r_s0_d - w_three_q);
    assign w_qup     = w_qd + ((w_r == 2'd2) ? 5'd1 : 5'd0);
    assign w_qdn     = w_qd - ((w_r == 2'd0) ? 5'd1 : 5'd0);
    assign w_c_raddr = {~r_s0_flags.vb, w_colw};

    always_comb begin
        logic [1:0] rel;
        for (int b = 0; b < 3; b++) begin
            // position of bank b relative to the bank of d
            rel = 2'(b) - w_r;
            if (2'(b) < w_r) rel = rel + 2'd3;
            case (rel)
                2'd0:    w_rq[b] = w_qd[QW-1:0];
                2'd1:    w_rq[b] = w_qup[QW-1:0];
                default: w_rq[b] = w_qdn[QW-1:0];
            endcase
            w_h_raddr[b] = {~r_s0_flags.hb, w_rq[b]};
            w_v_raddr[b] = {~r_s0_flags.vb, w_colw, w_rq[b]};
        end
    end

    // stage 1: path costs
    logic [CB-1:0] w_h, w_v, n_hrun, n_vrun, w_cmin_wd;
    logic [1:0]    w_up_b, w_dn_b;
    logic [HAW-1:0] w_h_waddr;
    logic [VAW-1:0] w_v_waddr;
    logic [CAW-1:0] w_c_waddr;

    assign w_up_b = spca_pkg::next_bank(r_s1_r);
    assign w_dn_b = spca_pkg::next_bank(w_up_b);

    always_comb begin
        if (r_s1_flags.first_col) begin
            w_h = CB'(r_s1_cost);
        end else begin
            w_h = f_path(r_s1_cost, r_hq[r_s1_r], r_hq[w_dn_b], r_hq[w_up_b],
                         r_s1_flags.use_dn, r_s1_flags.use_up, r_hprev, r_p1, r_p2);
        end
        if (r_s1_flags.first_row) begin
            w_v = CB'(r_s1_cost);
        end else begin
            w_v = f_path(r_s1_cost, r_vq[r_s1_r], r_vq[w_dn_b], r_vq[w_up_b],
                         r_s1_flags.use_dn, r_s1_flags.use_up, r_cmin, r_p1, r_p2);
        end
        if (r_s1_d == '0) begin
            n_hrun = w_h;
            n_vrun = w_v;
        end else begin
            n_hrun = (w_h < r_hrun) ? w_h : r_hrun;
            n_vrun = (w_v < r_vrun) ? w_v : r_vrun;
        end
        w_cmin_wd = r_s1_flags.first_row ? '0 : n_vrun;
    end

    assign w_h_waddr = {r_s1_flags.hb, r_s1_q};
    assign w_v_waddr = {r_s1_flags.vb, r_s1_colw, r_s1_q};
    assign w_c_waddr = {r_s1_flags.vb, r_s1_colw};

    // cost stores, one bank per disparity modulo three
    for (genvar b = 0; b < 3; b++) begin : g_bank
        logic [CB-1:0] hmem [2**HAW];
        logic [CB-1:0] vmem [2**VAW];
        logic          wsel;

        assign wsel = w_we && (r_s1_r == 2'(b));

        always_ff @(posedge i_clk) begin
            if (wsel) begin
                hmem[w_h_waddr] <= w_h;
                vmem[w_v_waddr] <= w_v;
            end
            if (w_rd_en) begin
                r_hq[b] <= (wsel && (w_h_waddr == w_h_raddr[b])) ? w_h : hmem[w_h_raddr[b]];
                r_vq[b] <= (wsel && (w_v_waddr == w_v_raddr[b])) ? w_v : vmem[w_v_raddr[b]];
            end
        end
    end

    // per-column minimum of the previous row
    logic [CB-1:0] cmin_mem [2**CAW];
    logic          w_cmin_we;

    assign w_cmin_we = w_we && r_s1_flags.done;

    always_ff @(posedge i_clk) begin
        if (w_cmin_we) begin
            cmin_mem[w_c_waddr] <= w_cmin_wd;
        end
        if (w_rd_en) begin
            r_cmin <= (w_cmin_we && (w_c_waddr == w_c_raddr)) ? w_cmin_wd : cmin_mem[w_c_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd        <= spca_pkg::NUM_DISP_RESET;
            r_p1        <= spca_pkg::SMALL_PEN_RESET;
            r_p2        <= spca_pkg::LARGE_PEN_RESET;
            r_s0_v      <= 1'b0;
            r_s1_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_bank      <= 1'b0;
            r_row       <= 1'b0;
            r_hprev     <= '0;
            r_hrun      <= '1;
            r_vrun      <= '1;
        end else begin
            if (i_cfg_valid) begin
                unique case (spca_pkg::t_cfg_index'(i_cfg_index))
                    spca_pkg::CFG_NUM_DISP:  r_nd <= i_cfg_data[NDW-1:0];
                    spca_pkg::CFG_SMALL_PEN: r_p1 <= i_cfg_data;
                    spca_pkg::CFG_LARGE_PEN: r_p2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_en0) r_s0_v <= s_axis_tvalid;
            if (w_en1) r_s1_v <= r_s0_v;
            if (w_en2) r_out_valid <= r_s1_v;
            if (w_accept && w_in_flags.in_range) begin
                r_row <= w_in_flags.vb;
                if (w_in_flags.done) r_bank <= ~r_bank;
            end
            if (w_we) begin
                if (r_s1_flags.done) begin
                    r_hprev <= r_s1_flags.first_col ? '0 : n_hrun;
                    r_hrun  <= '1;
                    r_vrun  <= '1;
                end else begin
                    r_hrun  <= n_hrun;
                    r_vrun  <= n_vrun;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_s0_cost  <= w_in_cost;
            r_s0_d     <= w_in_d;
            r_s0_col   <= w_in_col;
            r_s0_colq  <= w_colprod[KW+RSH-1:RSH];
            r_s0_flags <= w_in_flags;
        end
        if (w_en1) begin
            r_s1_cost  <= r_s0_cost;
            r_s1_d     <= r_s0_d;
            r_s1_r     <= w_r;
            r_s1_q     <= w_qd[QW-1:0];
            r_s1_colw  <= w_colw;
            r_s1_flags <= r_s0_flags;
        end
        if (w_en2) begin
            if (r_s1_flags.in_range) begin
                r_out_h    <= w_h;
                r_out_vc   <= w_v;
                r_out_sum  <= (CB+1)'(w_h) + (CB+1)'(w_v);
                r_out_last <= r_s1_flags.done;
            end else begin
                // disparity beyond the count: all fields zero
                r_out_h    <= '0;
                r_out_vc   <= '0;
                r_out_sum  <= '0;
                r_out_last <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_W'({r_out_sum, r_out_vc, r_out_h});

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_s1_flags.done) |=> (r_hrun == '1 && r_vrun == '1))
        else $error("run minima not restarted after last disparity");

    a_bank_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in_flags.in_range && w_in_flags.done) |=> (r_bank != $past(r_bank)))
        else $error("horizontal bank did not swap at end of pixel");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !w_en2) |=> (r_s1_v && $stable(r_s1_d) && $stable(r_hq[0])))
        else $error("stage 1 beat lost or changed while output stalled");

endmodule
